[hw/rtl/ogpa_pkg.sv]
// shared constants and types for the outlier gated position average
`timescale 1ns / 1ps
`default_nettype none

package ogpa_pkg;

	// window depth and coordinate width
	localparam int MAX_WINDOW = 16;
	localparam int COORD_BITS = 24;
	localparam int NUM_AXES   = 3;

	// derived widths
	localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W     = COORD_BITS + $clog2(MAX_WINDOW);
	localparam int DIFF_W    = COORD_BITS + 1;
	localparam int REJ_W     = 23;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = (REJ_W > LEN_W) ? REJ_W : LEN_W;
	localparam int GATE_W    = (DIFF_W > REJ_W) ? DIFF_W : REJ_W;
	localparam int LCMP_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;
	localparam int PROD_W    = 2 * REJ_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int REM_W     = CNT_W + 1;

	// stream widths, data padded to whole bytes
	localparam int IN_DATA_W  = ((NUM_AXES * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((NUM_AXES * COORD_BITS + CNT_W + 7) / 8) * 8;
	localparam int FLAG_W     = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

	// register reset values
	localparam logic [REJ_W-1:0] REJECT_RESET = 23'd2048;
	localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd10;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [NUM_AXES-1:0] sample_t;

	// per cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic tap;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/ogpa_cell.sv]
// one window cell: holds a sample, hands it on along the chain, offers it as the oldest
`timescale 1ns / 1ps
`default_nettype none

module ogpa_cell import ogpa_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  sample_t   sample_in,
	output sample_t   sample_out,
	output sample_t   tap
);

	sample_t sample_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= sample_in;
		end
	end

	assign sample_out = sample_q;
	// one-hot tap, or-ed with the other cells
	assign tap = ctl.tap ? sample_q : '0;

endmodule

`default_nettype wire

[hw/rtl/ogpa_div.sv]
// bit-serial signed divider of a window sum by the fill count, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none

module ogpa_div import ogpa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output coord_t                  quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     mag_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	coord_t               res_q;

	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_d;
	logic             quo_bit;
	logic [SUM_W-1:0] quo_mag;
	logic [SUM_W-1:0] quo_signed;

	// restoring step, one quotient bit per cycle
	always_comb begin
		trial      = {rem_q[REM_W-2:0], mag_q[SUM_W-1]};
		quo_bit    = trial >= {1'b0, div_q};
		rem_d      = quo_bit ? trial - {1'b0, div_q} : trial;
		quo_mag    = {mag_q[SUM_W-2:0], quo_bit};
		quo_signed = neg_q ? -quo_mag : quo_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			mag_q <= quo_mag;
			rem_q <= rem_d;
			if (cnt_q == '0) begin
				res_q <= quo_signed[COORD_BITS-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

endmodule

`default_nettype wire

[hw/rtl/outlier_gated_position_average_unit.sv]
// top level of the outlier gated sliding window position average
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window average of 3D positions (signed Q11.12 metres) with an outlier gate.
// A request with tuser low is a sample: while the window holds anything it is compared
// with the current mean and dropped when its distance exceeds reject_distance (squared
// test, no root); otherwise it is shifted into a chain of MAX_WINDOW cells, the oldest
// one falls out of the running sums once window_length is reached, and three bit-serial
// dividers form the new mean. A request with tuser high only stores a fallback position,
// which is what the block returns while the window is empty. Every request gives one
// result: the mean, accepted/rejected flags and the fill count. One request is worked at
// a time. An accepted sample goes through the gate (skipped for an empty window) and
// then the SUM_W-step (28) bit-serial dividers; a rejected one goes through the gate
// and a shared squarer, or the gate alone when one axis alone is beyond the radius; a
// fallback goes straight to the result. A result that finds the output register still
// full waits until it is taken.
// The next request is taken while a finished result waits in the output register.
// Configuration writes (index 0 reject_distance, 1 window_length) are always ready and
// are meant for times when no request is in flight.

module outlier_gated_position_average_unit import ogpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_x, sample_y, sample_z
	input  logic                  s_axis_tuser,   // mode
	// results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // mean_x, mean_y, mean_z, fill_count
	output logic [FLAG_W-1:0]     m_axis_tuser,   // accepted, rejected
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DIFF   = 6'b000010,
		S_SQ     = 6'b000100,
		S_DECIDE = 6'b001000,
		S_DIV    = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	// squarer schedule: three distances, then the radius
	localparam logic [2:0] SQ_X    = 3'd0;
	localparam logic [2:0] SQ_Y    = 3'd1;
	localparam logic [2:0] SQ_Z    = 3'd2;
	localparam logic [2:0] SQ_RR   = 3'd3;
	localparam logic [2:0] SQ_LAST = 3'd4;

	state_t state_q;
	state_t state_d;

	// block state
	sample_t                 fallback_q;
	logic [CNT_W-1:0]        occ_q;
	logic signed [SUM_W-1:0] sum_q [NUM_AXES];
	logic [REJ_W-1:0]        rej_dist_q;
	logic [LEN_W-1:0]        len_q;

	// working registers of the current request
	sample_t             p_q;
	logic [GATE_W-1:0]   abs_q [NUM_AXES];
	logic                far_q;
	logic [2:0]          sq_cnt_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [ACC_W-1:0]    acc_q;
	logic                acc_flag_q;
	logic                rej_flag_q;

	// output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [FLAG_W-1:0]     m_user_q;

	// combinational
	sample_t                 mean;
	sample_t                 mean_out;
	sample_t                 oldest;
	logic signed [DIFF_W-1:0] diff [NUM_AXES];
	logic [GATE_W-1:0]       abs_d [NUM_AXES];
	logic                    far_d;
	logic [LCMP_W-1:0]       len_ext;
	logic [LCMP_W-1:0]       len_eff;
	logic                    evict;
	logic [CNT_W-1:0]        occ_next;
	logic signed [SUM_W-1:0] sum_next [NUM_AXES];
	logic                    reject;
	logic                    commit;
	logic [REJ_W-1:0]        sq_op;
	logic                    out_free;
	logic                    in_req;
	logic [NUM_AXES-1:0]     div_done;
	coord_t                  div_res [NUM_AXES];

	// cell chain
	sample_t   chain [MAX_WINDOW];
	sample_t   taps  [MAX_WINDOW];
	cell_ctl_t cell_ctl [MAX_WINDOW];

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// ---------------------------------------------------------------- window chain
	// newest sample enters cell 0, cell k holds the (k+1)-th newest
	for (genvar w = 0; w < MAX_WINDOW; w++) begin : g_cell
		assign cell_ctl[w] = '{shift: commit, tap: (occ_q == CNT_W'(w + 1))};
		if (w == 0) begin : g_head
			ogpa_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[w]),
				.sample_in  (p_q),
				.sample_out (chain[w]),
				.tap        (taps[w])
			);
		end else begin : g_body
			ogpa_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[w]),
				.sample_in  (chain[w-1]),
				.sample_out (chain[w]),
				.tap        (taps[w])
			);
		end
	end

	// oldest held sample, picked by the fill count
	always_comb begin
		oldest = '0;
		for (int w = 0; w < MAX_WINDOW; w++) begin
			oldest = oldest | taps[w];
		end
	end

	// ---------------------------------------------------------------- mean dividers
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
		ogpa_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (commit),
			.dividend (sum_next[a]),
			.divisor  (occ_next),
			.done     (div_done[a]),
			.quotient (div_res[a])
		);
		assign mean[a] = div_res[a];
	end

	// window empty means the fallback stands in for the mean
	assign mean_out = (occ_q == '0) ? fallback_q : mean;

	// ---------------------------------------------------------------- gate
	always_comb begin
		far_d = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			diff[a]  = DIFF_W'($signed(p_q[a])) - DIFF_W'($signed(mean[a]));
			abs_d[a] = GATE_W'($unsigned(diff[a][DIFF_W-1] ? -diff[a] : diff[a]));
			far_d    = far_d | (abs_d[a] > GATE_W'(rej_dist_q));
		end
	end

	// one shared squarer; every operand fits the radius width once no axis is too far
	always_comb begin
		unique case (sq_cnt_q)
			SQ_X:    sq_op = abs_q[0][REJ_W-1:0];
			SQ_Y:    sq_op = abs_q[1][REJ_W-1:0];
			SQ_Z:    sq_op = abs_q[2][REJ_W-1:0];
			default: sq_op = rej_dist_q;
		endcase
	end

	// distance equal to the radius still passes
	assign reject = (occ_q != '0) && (far_q || (acc_q > ACC_W'(prod_s1)));
	assign commit = (state_q == S_DECIDE) && !reject;

	// ---------------------------------------------------------------- window update
	always_comb begin
		len_ext = LCMP_W'(len_q);
		priority if (len_ext == '0) begin
			len_eff = LCMP_W'(1);
		end else if (len_ext > LCMP_W'(MAX_WINDOW)) begin
			len_eff = LCMP_W'(MAX_WINDOW);
		end else begin
			len_eff = len_ext;
		end
		// at or above the length, drop the oldest and keep the count
		evict    = LCMP_W'(occ_q) >= len_eff;
		occ_next = evict ? occ_q : occ_q + CNT_W'(1);
		for (int a = 0; a < NUM_AXES; a++) begin
			sum_next[a] = sum_q[a] + SUM_W'($signed(p_q[a]))
				- (evict ? SUM_W'($signed(oldest[a])) : SUM_W'(0));
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = s_axis_tuser ? S_DONE : S_DIFF;
				end
			end
			S_DIFF: begin
				state_d = ((occ_q == '0) || far_d) ? S_DECIDE : S_SQ;
			end
			S_SQ: begin
				if (sq_cnt_q == SQ_LAST) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = reject ? S_DONE : S_DIV;
			end
			S_DIV: begin
				if (&div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			occ_q      <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= '0;
			end
			fallback_q <= '0;
			rej_dist_q <= REJECT_RESET;
			len_q      <= LENGTH_RESET;
			sq_cnt_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_REJECT: rej_dist_q <= cfg_data[REJ_W-1:0];
					CFG_LENGTH: len_q      <= cfg_data[LEN_W-1:0];
					default:    ;
				endcase
			end
			if (in_req && s_axis_tuser) begin
				fallback_q <= s_axis_tdata[NUM_AXES*COORD_BITS-1:0];
			end
			if (state_q == S_DIFF) begin
				sq_cnt_q <= '0;
			end else if (state_q == S_SQ) begin
				sq_cnt_q <= sq_cnt_q + 3'd1;
			end
			if (commit) begin
				occ_q <= occ_next;
				for (int a = 0; a < NUM_AXES; a++) begin
					sum_q[a] <= sum_next[a];
				end
			end
			if ((state_q == S_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request payload, gate pipeline and output payload
	always_ff @(posedge clk) begin
		if (in_req) begin
			p_q        <= s_axis_tdata[NUM_AXES*COORD_BITS-1:0];
			acc_flag_q <= 1'b0;
			rej_flag_q <= 1'b0;
		end
		if (state_q == S_DIFF) begin
			abs_q <= abs_d;
			far_q <= far_d;
		end
		if (state_q == S_SQ) begin
			prod_s1 <= sq_op * sq_op;
			if (sq_cnt_q == SQ_X) begin
				acc_q <= '0;
			end else if (sq_cnt_q <= SQ_RR) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
		if (state_q == S_DECIDE) begin
			acc_flag_q <= !reject;
			rej_flag_q <= reject;
		end
		if ((state_q == S_DONE) && out_free) begin
			m_data_q <= OUT_DATA_W'({occ_q, mean_out});
			m_user_q <= {rej_flag_q, acc_flag_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(MAX_WINDOW))
		else $error("fill count above window depth");

	a_occ_only_on_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DECIDE |=> $stable(occ_q))
		else $error("fill count moved outside the decide step");

	a_req_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> (state_q == S_DIFF) || (state_q == S_DONE))
		else $error("request taken but no work started");

	a_accept_has_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_user_q[0] |-> m_data_q[NUM_AXES*COORD_BITS +: CNT_W] != '0)
		else $error("accepted sample reported with an empty window");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		(|div_done) |-> (state_q == S_DIV) && (&div_done))
		else $error("divider lanes out of step with the sequencer");
`endif

endmodule

`default_nettype wire
